// File: hdl/assert_macros.svh
// Assertion macros shared by the checker modules of the point warp.
// No dependencies; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked a fixed number of cycles later.
`define ASSERT_AFTER(lbl, clk, rst_n, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// File: hdl/gcpw_pkg.sv
// Package of the Gaussian curve point warp: transfer types, register indexes,
// fixed-point constants and the exponential fraction table generator.
// No dependencies.
`timescale 1ns / 1ps

package gcpw_pkg;

  // One input transfer: the point and the running sums.
  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
  } item_t;

  // One result transfer: the updated sums.
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
  } result_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_LEN_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_LEN_Y = 3'd4;

  // Fixed-point constants in Q30.
  localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
  localparam logic [63:0] HALF_Q30  = 64'd1 << 29;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] LN2_Q30   = 64'd744261118;

  // Register stages of the exponential pipeline in each lane.
  localparam int unsigned GAUSS_LAT = 7;

  // Entry k of the table of 2^(-k/2^tbl_bits) in Q30, built from a Taylor
  // series of exp(-y) with twenty terms. Only ever called with constant
  // arguments, so it folds away at elaboration.
  function automatic logic [30:0] frac_tbl_entry(input int unsigned k,
                                                 input int unsigned tbl_bits);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    y    = ((64'(k) * LN2_Q30) + (64'd1 << (tbl_bits - 1))) >> tbl_bits;
    sum  = ONE_Q30;
    term = ONE_Q30;
    term = ((term * y + HALF_Q30) >> 30) / 64'd1;  sum = sum - term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd2;  sum = sum + term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd3;  sum = sum - term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd4;  sum = sum + term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd5;  sum = sum - term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd6;  sum = sum + term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd7;  sum = sum - term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd8;  sum = sum + term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd9;  sum = sum - term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd10; sum = sum + term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd11; sum = sum - term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd12; sum = sum + term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd13; sum = sum - term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd14; sum = sum + term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd15; sum = sum - term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd16; sum = sum + term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd17; sum = sum - term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd18; sum = sum + term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd19; sum = sum - term;
    term = ((term * y + HALF_Q30) >> 30) / 64'd20; sum = sum + term;
    if (k == 0) begin
      sum = ONE_Q30;
    end
    return sum[30:0];
  endfunction

endpackage

// File: hdl/gcpw_gauss.sv
// Seven-stage pipeline computing exp(-c*c*inv) in unsigned fixed point.
// Depends on gcpw_pkg (constants and the fraction table generator).
`timescale 1ns / 1ps

module gcpw_gauss #(
  parameter int unsigned FRAC_BITS      = 16,
  parameter int unsigned EXP_TABLE_BITS = 8
) (
  input  logic               clk_i,
  input  logic [31:0]        coord_i,
  input  logic [31:0]        inv_i,
  output logic [FRAC_BITS:0] exp_o
);
  import gcpw_pkg::*;

  localparam int unsigned TblN = 1 << EXP_TABLE_BITS;
  localparam int unsigned TW   = FRAC_BITS + 6;
  localparam int unsigned UW   = FRAC_BITS + 7;
  localparam int unsigned PW   = TW + 31;
  localparam logic [6:0]  ShBase = 7'(30 - FRAC_BITS);

  // Constant fraction table, one entry more than the index range so that
  // interpolation can read the next entry.
  logic [30:0] tbl [TblN+1];
  for (genvar k = 0; k <= TblN; k++) begin : g_tbl
    assign tbl[k] = frac_tbl_entry(k, EXP_TABLE_BITS);
  end

  logic [31:0]           mag;
  logic [63:0]           sq_q;
  logic [63:0]           p1_q, p2_q;
  logic [95:0]           full;
  logic [TW-1:0]         t_q;
  logic                  uf3_q;
  logic [PW-1:0]         lprod, lrnd;
  logic [UW-1:0]         u;
  logic [6:0]            n4_q, n5_q, n6_q;
  logic [FRAC_BITS-1:0]  f4_q;
  logic                  uf4_q, uf5_q, uf6_q;
  logic [30:0]           v_d, v_q;
  logic [6:0]            sh;
  logic [63:0]           erd;
  logic [FRAC_BITS:0]    e_d, exp_q;

  // Stage 1: exact square of the magnitude.
  always_comb begin
    mag = coord_i[31] ? (32'd0 - coord_i) : coord_i;
  end

  always_ff @(posedge clk_i) begin
    sq_q <= {32'd0, mag} * {32'd0, mag};
  end

  // Stage 2: two 32 by 32 partial products of square times reciprocal.
  always_ff @(posedge clk_i) begin
    p1_q <= {32'd0, sq_q[31:0]} * {32'd0, inv_i};
    p2_q <= {32'd0, sq_q[63:32]} * {32'd0, inv_i};
  end

  // Stage 3: assemble the exponent argument and flag underflow at 64.0.
  always_comb begin
    full = {32'd0, p1_q} + {p2_q, 32'd0};
  end

  always_ff @(posedge clk_i) begin
    t_q   <= full[2*FRAC_BITS +: TW];
    uf3_q <= |full[95:3*FRAC_BITS+6];
  end

  // Stage 4: change to base two and split into integer and fraction.
  always_comb begin
    lprod = PW'(t_q) * PW'(LOG2E_Q30);
    lrnd  = lprod + PW'(HALF_Q30);
    u     = lrnd[30 +: UW];
  end

  always_ff @(posedge clk_i) begin
    n4_q  <= u[FRAC_BITS +: 7];
    f4_q  <= u[FRAC_BITS-1:0];
    uf4_q <= uf3_q;
  end

  // Stages 5 and 6: table read, then interpolation on the low fraction bits.
  if (FRAC_BITS > EXP_TABLE_BITS) begin : g_interp
    localparam int unsigned D = FRAC_BITS - EXP_TABLE_BITS;
    logic [EXP_TABLE_BITS-1:0] idx;
    logic [EXP_TABLE_BITS:0]   idx_lo, idx_hi;
    logic [30:0]               lo_q, diff_q;
    logic [D-1:0]              rem_q;
    logic [30+D:0]             dprod;

    assign idx    = f4_q[FRAC_BITS-1 -: EXP_TABLE_BITS];
    assign idx_lo = {1'b0, idx};
    assign idx_hi = {1'b0, idx} + 1'b1;

    always_ff @(posedge clk_i) begin
      lo_q   <= tbl[idx_lo];
      diff_q <= tbl[idx_lo] - tbl[idx_hi];
      rem_q  <= f4_q[D-1:0];
    end

    assign dprod = (31+D)'(diff_q) * (31+D)'(rem_q);
    assign v_d   = lo_q - dprod[D +: 31];
  end else begin : g_direct
    logic [EXP_TABLE_BITS-1:0] idx;
    logic [EXP_TABLE_BITS:0]   idx_lo;
    logic [30:0]               lo_q;

    assign idx    = EXP_TABLE_BITS'(f4_q) << (EXP_TABLE_BITS - FRAC_BITS);
    assign idx_lo = {1'b0, idx};

    always_ff @(posedge clk_i) begin
      lo_q <= tbl[idx_lo];
    end

    assign v_d = lo_q;
  end

  always_ff @(posedge clk_i) begin
    n5_q  <= n4_q;
    uf5_q <= uf4_q;
    v_q   <= v_d;
    n6_q  <= n5_q;
    uf6_q <= uf5_q;
  end

  // Stage 7: scale by the integer power of two with round half up.
  always_comb begin
    sh  = ShBase + n6_q;
    erd = 64'(v_q) + (64'd1 << (sh - 7'd1));
    if (uf6_q || (sh >= 7'd62)) begin
      e_d = '0;
    end else begin
      e_d = (FRAC_BITS+1)'(erd >> sh);
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q <= e_d;
  end

  assign exp_o = exp_q;

endmodule

// File: hdl/gcpw_lane.sv
// One axis lane: linear term, Gaussian bump and the three-term sum, unsaturated.
// Depends on gcpw_pkg and gcpw_gauss.
`timescale 1ns / 1ps

module gcpw_lane #(
  parameter int unsigned FRAC_BITS      = 16,
  parameter int unsigned EXP_TABLE_BITS = 8
) (
  input  logic                      clk_i,
  input  logic signed [31:0]        own_i,
  input  logic signed [31:0]        other_i,
  input  logic signed [31:0]        acc_i,
  input  logic signed [31:0]        weight_i,
  input  logic signed [31:0]        amp_i,
  input  logic [31:0]               inv_i,
  output logic signed [65-FRAC_BITS:0] sum_o
);
  import gcpw_pkg::*;

  localparam int unsigned LW = 64 - FRAC_BITS;
  localparam int unsigned SW = LW + 2;

  logic signed [63:0]           lin_full;
  logic signed [LW-1:0]         lin_q [GAUSS_LAT];
  logic signed [31:0]           acc_q [GAUSS_LAT];
  logic [FRAC_BITS:0]           exp_v;
  logic signed [33+FRAC_BITS:0] bump_full;
  logic signed [33:0]           bump_q;
  logic signed [LW-1:0]         lin8_q;
  logic signed [31:0]           acc8_q;
  logic signed [SW-1:0]         sum_q;

  // Exponential of the other coordinate.
  gcpw_gauss #(
    .FRAC_BITS      (FRAC_BITS),
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_gauss (
    .clk_i   (clk_i),
    .coord_i (other_i),
    .inv_i   (inv_i),
    .exp_o   (exp_v)
  );

  // Linear term with floor rounding, then delayed to meet the exponential.
  assign lin_full = weight_i * own_i;

  always_ff @(posedge clk_i) begin
    lin_q[0] <= lin_full[63:FRAC_BITS];
    acc_q[0] <= acc_i;
    for (int i = 1; i < GAUSS_LAT; i++) begin
      lin_q[i] <= lin_q[i-1];
      acc_q[i] <= acc_q[i-1];
    end
  end

  // Bump term: amplitude times exponential, floor rounding.
  assign bump_full = amp_i * $signed({1'b0, exp_v});

  always_ff @(posedge clk_i) begin
    bump_q <= bump_full[FRAC_BITS +: 34];
    lin8_q <= lin_q[GAUSS_LAT-1];
    acc8_q <= acc_q[GAUSS_LAT-1];
  end

  // Exact three-term sum; saturation happens in the merge stage.
  always_ff @(posedge clk_i) begin
    sum_q <= {{(SW-32){acc8_q[31]}}, acc8_q}
           + {{2{lin8_q[LW-1]}}, lin8_q}
           + {{(SW-34){bump_q[33]}}, bump_q};
  end

  assign sum_o = sum_q;

endmodule

// File: hdl/gcpw_merge.sv
// Merge stage: saturates both lane sums and registers the result transfer.
// Depends on gcpw_pkg (result type).
`timescale 1ns / 1ps

module gcpw_merge #(
  parameter int unsigned SUM_W = 50
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [SUM_W-1:0] sum_x_i,
  input  logic signed [SUM_W-1:0] sum_y_i,
  output gcpw_pkg::result_t       result_o,
  output logic                    done_o
);
  import gcpw_pkg::*;

  result_t result_d, result_q;
  logic    done_q;

  // Clamp a wide signed sum to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic [SUM_W-1:0] s);
    logic fits;
    fits = (s[SUM_W-1:31] == {(SUM_W-31){s[SUM_W-1]}});
    if (fits) begin
      return s[31:0];
    end else if (s[SUM_W-1]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

  always_comb begin
    result_d.out_x = sat32(sum_x_i);
    result_d.out_y = sat32(sum_y_i);
  end

  // The strobe is control state; the payload register needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_o = result_q;
  assign done_o   = done_q;

endmodule

// File: hdl/gaussian_curve_point_warp.sv
// Each accepted point yields one result transfer, flagged by done_o.
// Throughput: one point per cycle; busy stays low, so start may be held high.
// Each point passes the seven-stage exponential pipeline in each axis lane,
// then the bump multiply, the wide sum and the saturating output register.
// Reset (rst_ni, asynchronous, active low) restores register defaults and
// clears the valid pipeline; results cannot be held off by the receiver.
`timescale 1ns / 1ps

module gaussian_curve_point_warp #(
  parameter int unsigned FRAC_BITS      = 16,
  parameter int unsigned EXP_TABLE_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  gcpw_pkg::item_t                   item_i,
  output gcpw_pkg::result_t                 result_o,
  output logic                              done_o,
  input  logic                              cfg_we_i,
  input  logic [gcpw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [31:0]                       cfg_data_i
);
  import gcpw_pkg::*;

  localparam int unsigned LaneLat = GAUSS_LAT + 2;
  localparam int unsigned Latency = LaneLat + 1;
  localparam int unsigned SumW    = 66 - FRAC_BITS;
  localparam logic [31:0] OneFx   = 32'd1 << FRAC_BITS;

  logic                   accept;
  logic [LaneLat-1:0]     vld_q;
  logic [31:0]            weight_q, amp_x_q, amp_y_q, inv_x_q, inv_y_q;
  logic signed [SumW-1:0] sum_x, sum_y;

  // Every cycle is open for a new transfer.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= OneFx;
      amp_x_q  <= '0;
      amp_y_q  <= '0;
      inv_x_q  <= OneFx;
      inv_y_q  <= OneFx;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WEIGHT:    weight_q <= cfg_data_i;
        REG_AMP_X:     amp_x_q  <= cfg_data_i;
        REG_AMP_Y:     amp_y_q  <= cfg_data_i;
        REG_INV_LEN_X: inv_x_q  <= cfg_data_i;
        REG_INV_LEN_Y: inv_y_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits travelling alongside the lane pipelines.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LaneLat-2:0], accept};
    end
  end

  // X lane: bump driven by ty.
  gcpw_lane #(
    .FRAC_BITS      (FRAC_BITS),
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_lane_x (
    .clk_i    (clk_i),
    .own_i    (item_i.tx),
    .other_i  (item_i.ty),
    .acc_i    (item_i.acc_x),
    .weight_i (weight_q),
    .amp_i    (amp_x_q),
    .inv_i    (inv_x_q),
    .sum_o    (sum_x)
  );

  // Y lane: bump driven by tx.
  gcpw_lane #(
    .FRAC_BITS      (FRAC_BITS),
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_lane_y (
    .clk_i    (clk_i),
    .own_i    (item_i.ty),
    .other_i  (item_i.tx),
    .acc_i    (item_i.acc_y),
    .weight_i (weight_q),
    .amp_i    (amp_y_q),
    .inv_i    (inv_y_q),
    .sum_o    (sum_y)
  );

  // Saturate and register both axes into one result transfer.
  gcpw_merge #(
    .SUM_W (SumW)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vld_q[LaneLat-1]),
    .sum_x_i  (sum_x),
    .sum_y_i  (sum_y),
    .result_o (result_o),
    .done_o   (done_o)
  );

endmodule

// File: hdl/gcpw_checker.sv
// Port-level checker for the point warp, attached to the top level by bind.
// Depends on assert_macros.svh and gaussian_curve_point_warp.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gcpw_checker #(
  parameter int unsigned LATENCY = 10
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_i
);

  logic xfer;

  // An input transfer is accepted whenever start meets a low busy.
  assign xfer = start && !busy;

  // Every accepted transfer yields exactly one strobe after the fixed latency.
  `ASSERT_AFTER(a_result_follows, clk_i, rst_ni, xfer, LATENCY, done_i, "point gave no result")
  `ASSERT_IMPLY(a_no_phantom, clk_i, rst_ni, done_i, $past(xfer, LATENCY), "stray result")

  // The block is always open for the next point.
  `ASSERT_IMPLY(a_always_ready, clk_i, rst_ni, start, !busy, "start refused while streaming")

endmodule

bind gaussian_curve_point_warp gcpw_checker #(
  .LATENCY (Latency)
) u_gcpw_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_i (done_o)
);

// File: tb/testbench.sv
// Self-checking testbench for gaussian_curve_point_warp: a queued driver with
// its own bit-exact predictor, a result monitor and a stall watchdog.
// Depends on hdl/gcpw_pkg.sv and hdl/gaussian_curve_point_warp.sv.
`timescale 1ns / 1ps

module testbench;
  import gcpw_pkg::*;

  localparam int unsigned FRAC          = 16;
  localparam int unsigned TBL_BITS      = 8;
  localparam int unsigned TBL_N         = 1 << TBL_BITS;
  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned WATCHDOG_MAX  = 500;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_POINTS  = 178;
  localparam bit [63:0]   Q30_UNIT      = 64'd1 << 30;
  localparam bit [63:0]   LN2_FIX       = 64'd744261118;
  localparam bit [63:0]   LOG2E_FIX     = 64'd1549082005;
  localparam bit [127:0]  ARG_CEILING   = 128'd64 << FRAC;

  // Register indexes past the last implemented register; writes there are dropped.
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_C = 3'd7;

  typedef enum logic [1:0] {OP_POINT, OP_WRITE, OP_PAUSE} op_kind_e;

  typedef struct {
    op_kind_e              kind;
    item_t                 pt;
    logic [CFG_IDX_W-1:0]  idx;
    logic [31:0]           data;
    int unsigned           hold;
  } stim_op_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  start      = 1'b0;
  logic                  busy;
  item_t                 item_i     = '0;
  result_t               result_o;
  logic                  done_o;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [31:0]           cfg_data_i = '0;

  // Shadow copy of the configuration registers, at their reset values.
  logic signed [31:0] weight_m = 32'sh0001_0000;
  logic signed [31:0] amp_x_m  = 32'sh0;
  logic signed [31:0] amp_y_m  = 32'sh0;
  bit [31:0]          inv_x_m  = 32'h0001_0000;
  bit [31:0]          inv_y_m  = 32'h0001_0000;

  bit [63:0]   exp2_frac_tbl [0:TBL_N];
  stim_op_t    pending_q [$];
  result_t     expected_q [$];
  int unsigned accepted_cnt = 0;
  int unsigned received_cnt = 0;
  int unsigned hold_cnt     = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors       = 0;
  bit          stim_empty   = 1'b0;

  gaussian_curve_point_warp uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .result_o   (result_o),
    .done_o     (done_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // 125 MHz clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // exp(-c*c*inv) as unsigned fixed point: base-2 range reduction, table
  // lookup with linear interpolation, then a rounding shift.
  function automatic bit [63:0] gauss_gain(input logic signed [31:0] coord,
                                           input bit [31:0] inv);
    bit [63:0]   mag;
    bit [63:0]   sq;
    bit [127:0]  scaled;
    bit [63:0]   t;
    bit [63:0]   u;
    bit [63:0]   n;
    bit [63:0]   f;
    bit [63:0]   rem;
    bit [63:0]   v;
    int unsigned idx;
    int unsigned sh;
    mag    = {32'd0, coord[31] ? 32'(-coord) : 32'(coord)};
    sq     = mag * mag;
    scaled = {64'd0, sq} * {96'd0, inv};
    // Arguments of 64.0 and above underflow to zero.
    if ((scaled >> (2 * FRAC)) >= ARG_CEILING) begin
      return 64'd0;
    end
    t   = scaled[2*FRAC +: 64];
    u   = (t * LOG2E_FIX + (Q30_UNIT >> 1)) >> 30;
    n   = u >> FRAC;
    f   = u & ((64'd1 << FRAC) - 64'd1);
    idx = int'(f >> (FRAC - TBL_BITS));
    rem = f & ((64'd1 << (FRAC - TBL_BITS)) - 64'd1);
    v   = exp2_frac_tbl[idx]
          - (((exp2_frac_tbl[idx] - exp2_frac_tbl[idx + 1]) * rem) >> (FRAC - TBL_BITS));
    sh  = 30 - FRAC + int'(n);
    // Very large exponents shift everything out.
    if (sh >= 62) begin
      return 64'd0;
    end
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  // One axis: running sum plus the weighted own coordinate plus the bump of
  // the other coordinate, both products floored, the total saturated.
  function automatic logic signed [31:0] warp_axis(input logic signed [31:0] acc, own,
                                                   other, amp,
                                                   input bit [31:0] inv);
    longint lin;
    longint bump;
    longint total;
    lin   = (longint'(weight_m) * longint'(own)) >>> FRAC;
    bump  = (longint'(amp) * longint'(gauss_gain(other, inv))) >>> FRAC;
    total = longint'(acc) + lin + bump;
    if (total > 64'sd2147483647) begin
      total = 64'sd2147483647;
    end else if (total < -64'sd2147483648) begin
      total = -64'sd2147483648;
    end
    return total[31:0];
  endfunction

  function automatic result_t warp_point(input item_t pt);
    result_t r;
    r.out_x = warp_axis(pt.acc_x, pt.tx, pt.ty, amp_x_m, inv_x_m);
    r.out_y = warp_axis(pt.acc_y, pt.ty, pt.tx, amp_y_m, inv_y_m);
    return r;
  endfunction

  // Random word with its magnitude spread over all widths, and now and then
  // one of the corner values.
  function automatic logic [31:0] shaped_word(input bit allow_neg);
    logic [31:0] v;
    int unsigned w;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 4))
        0:       v = 32'h0000_0000;
        1:       v = 32'h7FFF_FFFF;
        2:       v = 32'h8000_0000;
        3:       v = 32'hFFFF_FFFF;
        default: v = 32'h0001_0000;
      endcase
    end else begin
      w = $urandom_range(0, 32);
      v = (w == 32) ? $urandom : ($urandom & ((32'd1 << w) - 32'd1));
      if (allow_neg && $urandom_range(0, 1) == 1) begin
        v = -v;
      end
    end
    return v;
  endfunction

  task automatic push_point(input logic [31:0] tx, ty, ax, ay, input int unsigned hold);
    stim_op_t op;
    op.kind     = OP_POINT;
    op.pt.tx    = tx;
    op.pt.ty    = ty;
    op.pt.acc_x = ax;
    op.pt.acc_y = ay;
    op.idx      = '0;
    op.data     = '0;
    op.hold     = hold;
    pending_q.push_back(op);
  endtask

  task automatic push_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    stim_op_t op;
    op.kind = OP_WRITE;
    op.pt   = '0;
    op.idx  = idx;
    op.data = data;
    op.hold = 0;
    pending_q.push_back(op);
  endtask

  task automatic push_pause();
    stim_op_t op;
    op.kind = OP_PAUSE;
    op.pt   = '0;
    op.idx  = '0;
    op.data = '0;
    op.hold = 0;
    pending_q.push_back(op);
  endtask

  // Driver: presents points, predicts each one at its accepting edge, and
  // issues register writes only once every outstanding result is back.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    stim_op_t op;
    logic     nxt_start;
    logic     nxt_we;
    logic     drained;
    if (!rst_ni) begin
      start    <= 1'b0;
      cfg_we_i <= 1'b0;
      hold_cnt <= 0;
    end else begin
      nxt_start = start;
      nxt_we    = 1'b0;
      drained   = !start && (accepted_cnt == received_cnt);
      if (start && !busy) begin
        expected_q.push_back(warp_point(item_i));
        accepted_cnt <= accepted_cnt + 1;
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (pending_q.size() == 0) begin
          stim_empty <= drained;
        end else begin
          op = pending_q[0];
          case (op.kind)
            OP_POINT: begin
              if (hold_cnt >= op.hold) begin
                item_i    <= op.pt;
                nxt_start = 1'b1;
                hold_cnt  <= 0;
                void'(pending_q.pop_front());
              end else begin
                hold_cnt <= hold_cnt + 1;
              end
            end
            OP_WRITE: begin
              if (drained) begin
                nxt_we     = 1'b1;
                cfg_idx_i  <= op.idx;
                cfg_data_i <= op.data;
                case (op.idx)
                  REG_WEIGHT:    weight_m = op.data;
                  REG_AMP_X:     amp_x_m  = op.data;
                  REG_AMP_Y:     amp_y_m  = op.data;
                  REG_INV_LEN_X: inv_x_m  = op.data;
                  REG_INV_LEN_Y: inv_y_m  = op.data;
                  default: ;
                endcase
                void'(pending_q.pop_front());
              end
            end
            default: begin
              if (drained) begin
                void'(pending_q.pop_front());
              end
            end
          endcase
        end
      end
      start    <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    if (!rst_ni) begin
      received_cnt <= 0;
    end else if (done_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got out_x=%0d out_y=%0d",
                 $time, result_o.out_x, result_o.out_y);
        errors++;
      end else begin
        want = expected_q.pop_front();
        received_cnt <= received_cnt + 1;
        if (result_o.out_x !== want.out_x) begin
          $display("%0t: out_x mismatch, expected %0d, got %0d",
                   $time, want.out_x, result_o.out_x);
          errors++;
        end
        if (result_o.out_y !== want.out_y) begin
          $display("%0t: out_y mismatch, expected %0d, got %0d",
                   $time, want.out_y, result_o.out_y);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer or register write ends the run.
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((start && !busy) || done_o || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_q.size());
        $display("testbench: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    bit [63:0]   y;
    bit [63:0]   term;
    bit [63:0]   sum;
    bit          burst;
    int unsigned hold;

    // Fraction table of 2^(-k/N) in Q30 from a twenty-term series.
    for (int k = 0; k <= TBL_N; k++) begin
      y    = (64'(k) * LN2_FIX + 64'(TBL_N / 2)) / 64'(TBL_N);
      sum  = Q30_UNIT;
      term = Q30_UNIT;
      for (int i = 1; i <= 20; i++) begin
        term = ((term * y + (Q30_UNIT >> 1)) >> 30) / 64'(i);
        sum  = (i % 2 == 1) ? sum - term : sum + term;
      end
      exp2_frac_tbl[k] = sum;
    end
    exp2_frac_tbl[0] = Q30_UNIT;

    // A few points under the reset configuration, where the bumps are zero.
    push_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0005, 32'hFFFF_FFFB, 0);
    push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 0);

    // Unit weight, bumps of 2.0 and -3.0; stray writes above the last
    // register must leave everything as it is.
    push_write(REG_WEIGHT,    32'h0001_0000);
    push_write(REG_AMP_X,     32'h0002_0000);
    push_write(REG_AMP_Y,     32'hFFFD_0000);
    push_write(REG_INV_LEN_X, 32'h0001_0000);
    push_write(REG_INV_LEN_Y, 32'h0000_8000);
    push_write(IDX_SPARE_A,   32'hDEAD_0000);
    push_write(IDX_SPARE_C,   32'hFFFF_FFFF);
    // Zero argument gives exactly one.
    push_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0);
    push_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000, 0);
    // Saturation at both ends.
    push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 3);
    // Argument of 36: the final shift clears the exponential.
    push_point(32'h0000_0000, 32'h0006_0000, 32'h0000_0000, 32'h0000_0000, 0);
    // Argument of exactly 64 underflows; one step below it does not yet.
    push_point(32'h0000_0000, 32'h0008_0000, 32'h0000_0000, 32'h0000_0000, 0);
    push_point(32'h0000_0000, 32'h0007_FFFF, 32'h0000_0000, 32'h0000_0000, 0);
    // Mid-range arguments that use the interpolation.
    push_point(32'h0005_8000, 32'h0000_C000, 32'h0000_0000, 32'h0000_0000, 1);
    push_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 0);
    push_point(32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 0);
    push_pause();

    // Negative half weight for floor rounding; zero and full-scale lengths.
    push_write(REG_WEIGHT,    32'hFFFF_8000);
    push_write(REG_AMP_X,     32'h7FFF_FFFF);
    push_write(REG_AMP_Y,     32'h8000_0000);
    push_write(REG_INV_LEN_X, 32'h0000_0000);
    push_write(REG_INV_LEN_Y, 32'hFFFF_FFFF);
    push_write(IDX_SPARE_B,   32'h1234_5678);
    push_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 0);
    push_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 0);
    push_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0);
    push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 2);
    push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    push_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 0);

    // Random phases, each under its own configuration; the first two
    // take the register extremes.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          push_write(REG_WEIGHT,    32'h7FFF_FFFF);
          push_write(REG_AMP_X,     32'h7FFF_FFFF);
          push_write(REG_AMP_Y,     32'h8000_0000);
          push_write(REG_INV_LEN_X, 32'hFFFF_FFFF);
          push_write(REG_INV_LEN_Y, 32'h0000_0000);
        end
        1: begin
          push_write(REG_WEIGHT,    32'h8000_0000);
          push_write(REG_AMP_X,     32'h8000_0000);
          push_write(REG_AMP_Y,     32'h7FFF_FFFF);
          push_write(REG_INV_LEN_X, 32'h0000_0000);
          push_write(REG_INV_LEN_Y, 32'h0000_0001);
        end
        default: begin
          push_write(REG_WEIGHT,    shaped_word(1'b1));
          push_write(REG_AMP_X,     shaped_word(1'b1));
          push_write(REG_AMP_Y,     shaped_word(1'b1));
          push_write(REG_INV_LEN_X, shaped_word(1'b0));
          push_write(REG_INV_LEN_Y, shaped_word(1'b0));
        end
      endcase
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 2))
          0:       push_write(IDX_SPARE_A, $urandom);
          1:       push_write(IDX_SPARE_B, $urandom);
          default: push_write(IDX_SPARE_C, $urandom);
        endcase
      end
      burst = 1'b0;
      for (int k = 0; k < PHASE_POINTS; k++) begin
        // Gaps are drawn in groups so that back-to-back stretches occur.
        if (k % 20 == 0) begin
          burst = ($urandom_range(0, 2) == 0);
        end
        hold = burst ? 0 : $urandom_range(0, 19);
        push_point(shaped_word(1'b1), shaped_word(1'b1),
                   shaped_word(1'b1), shaped_word(1'b1), hold);
        if (k == PHASE_POINTS / 2) begin
          push_pause();
        end
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!stim_empty) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
